[rtl/core/mds_pkg.sv]
// Package for the multibyte delimiter splitter.
// Word types, configuration register indexes and cell control codes.
// No dependencies; every module of the splitter imports it.
`default_nettype none

package mds_pkg;

    // Default cell count: the longest delimiter the block can hold.
    localparam int MAX_DELIM_DEF = 8;
    // Bytes held by the delimiter register.
    localparam int DELIM_BYTES = 8;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RST  = 64'd124;
    localparam logic [LEN_W-1:0]      DELIM_LENGTH_RST = 4'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_last;
    } in_word_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       field_end;
        logic       string_end;
        logic       run_last;
    } out_word_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT1,
        CELL_SHIFTL,
        CELL_LOAD
    } cell_op_t;

    // Compare results of one cell against the delimiter byte at its position.
    typedef struct packed {
        logic eq_here;
        logic eq_nbr;
        logic eq_far;
    } cell_cmp_t;

    typedef struct packed {
        logic active;
        logic last;
    } ctrl_stat_t;

endpackage

`default_nettype wire

[rtl/core/mds_cell.sv]
// One cell of the pending byte chain of the delimiter splitter.
// Holds one byte and compares three candidate bytes with its delimiter byte.
// Depends on mds_pkg.
`default_nettype none

module mds_cell
    import mds_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_op_t   op,
    input  wire logic [7:0] delim_byte,
    input  wire logic [7:0] nbr_byte,
    input  wire logic [7:0] far_byte,
    input  wire logic [7:0] load_byte,
    output      logic [7:0] data,
    output      cell_cmp_t  cmp
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        case (op)
            CELL_HOLD:   data_next = data_reg;
            CELL_SHIFT1: data_next = nbr_byte;
            CELL_SHIFTL: data_next = far_byte;
            CELL_LOAD:   data_next = load_byte;
            default:     data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // The neighbor and far compares tell the scanner how the chain will
    // look after a shift by one byte or by a whole delimiter.
    assign data        = data_reg;
    assign cmp.eq_here = (data_reg == delim_byte);
    assign cmp.eq_nbr  = (nbr_byte == delim_byte);
    assign cmp.eq_far  = (far_byte == delim_byte);

endmodule

`default_nettype wire

[rtl/core/mds_ctrl.sv]
// Scan control of the delimiter splitter: fill count, string state,
// per-cycle result choice, cell operations and the output word register.
// Depends on mds_pkg.
`default_nettype none

module mds_ctrl
    import mds_pkg::*;
#(
    parameter int MAX_DELIM = MAX_DELIM_DEF,
    localparam int CNT_W = $clog2(MAX_DELIM + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [LEN_W-1:0] len_cfg,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic             string_last,
    input  wire cell_cmp_t        cmp [MAX_DELIM],
    input  wire logic [7:0]       head_byte,
    output      cell_op_t         ops [MAX_DELIM],
    output      logic [LEN_W-1:0] len_eff,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      out_word_t        out_word,
    output      logic [CNT_W-1:0] count,
    output      ctrl_stat_t       stat
);

    localparam int MW = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             active_reg, active_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_word_reg;

    logic [MW-1:0] cnt, ln, cnt1, cntl, c0, c1, cl, count_after;
    logic          match0, match1, matchl;
    logic          full, partial, stable1, stablel;
    logic          out_free, emit, finish, shift1, shiftl, clr, last_clr, acc;
    out_word_t     res;

    // Lengths above eight, or above the cell count, act as the smaller one.
    always_comb
    begin
        len_eff = len_cfg;
        if (len_eff > LEN_W'(8))
        begin
            len_eff = LEN_W'(8);
        end
        if (int'(len_eff) > MAX_DELIM)
        begin
            len_eff = LEN_W'(MAX_DELIM);
        end
    end

    always_comb
    begin
        cnt  = MW'(count_reg);
        ln   = MW'(len_eff);
        cnt1 = cnt - MW'(1);
        cntl = cnt - ln;
        c0   = (cnt < ln) ? cnt : ln;
        c1   = (cnt1 < ln) ? cnt1 : ln;
        cl   = (cntl < ln) ? cntl : ln;
        match0 = 1'b1;
        match1 = 1'b1;
        matchl = 1'b1;
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            if (MW'(i) < c0 && !cmp[i].eq_here)
            begin
                match0 = 1'b0;
            end
            if (MW'(i) < c1 && !cmp[i].eq_nbr)
            begin
                match1 = 1'b0;
            end
            if (MW'(i) < cl && !cmp[i].eq_far)
            begin
                matchl = 1'b0;
            end
        end
        full    = match0 && (cnt >= ln) && (cnt != '0);
        partial = match0 && (cnt < ln) && (cnt != '0);
        // After the step the chain is settled when it is empty or holds
        // only the start of a possible delimiter.
        stable1 = (cnt1 == '0) || ((cnt1 < ln) && match1);
        stablel = (cntl == '0) || ((cntl < ln) && matchl);
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        res      = '0;
        emit     = 1'b0;
        finish   = 1'b0;
        shift1   = 1'b0;
        shiftl   = 1'b0;
        clr      = 1'b0;
        last_clr = 1'b0;
        if (active_reg)
        begin
            if (len_eff == '0)
            begin
                finish   = 1'b1;
                clr      = 1'b1;
                last_clr = 1'b1;
            end
            else if (!last_reg)
            begin
                if (cnt == '0 || partial)
                begin
                    finish = 1'b1;
                end
                else if (full)
                begin
                    res.field_end = 1'b1;
                    if (out_free)
                    begin
                        emit   = 1'b1;
                        shiftl = 1'b1;
                        finish = stablel;
                    end
                end
                else
                begin
                    res.has_byte = 1'b1;
                    res.out_byte = head_byte;
                    if (out_free)
                    begin
                        emit   = 1'b1;
                        shift1 = 1'b1;
                        finish = stable1;
                    end
                end
            end
            else
            begin
                // Flush: held bytes leave as content and full matches as field ends, then the string closes.
                if (cnt == '0)
                begin
                    res.field_end  = 1'b1;
                    res.string_end = 1'b1;
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        finish   = 1'b1;
                        last_clr = 1'b1;
                    end
                end
                else if (full)
                begin
                    res.field_end = 1'b1;
                    if (out_free)
                    begin
                        emit   = 1'b1;
                        shiftl = 1'b1;
                    end
                end
                else
                begin
                    res.has_byte = 1'b1;
                    res.out_byte = head_byte;
                    if (out_free)
                    begin
                        emit   = 1'b1;
                        shift1 = 1'b1;
                    end
                end
            end
        end
        res.run_last = finish;
    end

    always_comb
    begin
        if (clr)
        begin
            count_after = '0;
        end
        else if (shiftl)
        begin
            count_after = cntl;
        end
        else if (shift1)
        begin
            count_after = cnt1;
        end
        else
        begin
            count_after = cnt;
        end
    end

    assign in_ready = !active_reg || finish;
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        if (acc)
        begin
            if (len_eff == '0)
            begin
                count_next  = '0;
                active_next = 1'b0;
                last_next   = 1'b0;
            end
            else
            begin
                count_next  = CNT_W'(count_after + MW'(1));
                active_next = 1'b1;
                last_next   = string_last;
            end
        end
        else
        begin
            count_next  = CNT_W'(count_after);
            active_next = active_reg && !finish;
            last_next   = last_reg && !last_clr;
        end
        out_valid_next = emit || (out_valid_reg && !out_ready);
    end

    // The incoming byte lands right behind whatever is left after this
    // cycle's shift, so a new word enters in the cycle the last one settles.
    always_comb
    begin
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            if (acc && len_eff != '0 && MW'(i) == count_after)
            begin
                ops[i] = CELL_LOAD;
            end
            else if (shift1)
            begin
                ops[i] = CELL_SHIFT1;
            end
            else if (shiftl)
            begin
                ops[i] = CELL_SHIFTL;
            end
            else
            begin
                ops[i] = CELL_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            active_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            active_reg    <= active_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_word    = out_word_reg;
    assign count       = count_reg;
    assign stat.active = active_reg;
    assign stat.last   = last_reg;

endmodule

`default_nettype wire

[rtl/core/multibyte_delimiter_splitter_top.sv]
// Top level of the multibyte delimiter splitter: configuration registers,
// the chain of pending byte cells and the scan control.
// Depends on mds_pkg, mds_cell and mds_ctrl.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_ready  | in_word  (data_byte, string_last)
//  out     | output    | out_valid/out_ready| out_word (has_byte .. run_last)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each cycle the scan takes one decision on the head of the cell chain and
// delivers at most one word; plain bytes stream at one per cycle while the
// output is not stalled. A full delimiter match is dropped by a single
// shift of its length. The final byte of a string starts a flush of the
// held bytes, followed by the closing word. Reset clears the fill count,
// the string state and the output valid flag; the configuration returns
// to a one-byte '|' delimiter. A stalled output holds the scan, and a new
// byte waits until the previous byte's words have all entered the output
// register.
`default_nettype none

module multibyte_delimiter_splitter_top
    import mds_pkg::*;
#(
    parameter int MAX_DELIM = MAX_DELIM_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire in_word_t              in_word,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      out_word_t             out_word,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_DELIM + 1);
    localparam int PAD_N = MAX_DELIM + DELIM_BYTES;

    logic [CFG_DATA_W-1:0] delim_reg, delim_next;
    logic [LEN_W-1:0]      len_reg, len_next;

    logic [LEN_W-1:0] len_eff;
    logic [CNT_W-1:0] count_q;
    ctrl_stat_t       stat;
    cell_op_t         ops [MAX_DELIM];
    cell_cmp_t        cmp [MAX_DELIM];
    logic [7:0]       cell_data [MAX_DELIM];
    logic [7:0]       cell_pad [PAD_N];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        delim_next = delim_reg;
        len_next   = len_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_DELIM_BYTES)
            begin
                delim_next = cfg_data;
            end
            else if (cfg_index == REG_DELIM_LENGTH)
            begin
                len_next = cfg_data[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_BYTES_RST;
            len_reg   <= DELIM_LENGTH_RST;
        end
        else
        begin
            delim_reg <= delim_next;
            len_reg   <= len_next;
        end
    end

    // Bytes past the end of the chain read as zero; they are never compared
    // inside the active part of a window.
    for (genvar j = 0; j < PAD_N; j++)
    begin : g_pad
        if (j < MAX_DELIM)
        begin : g_live
            assign cell_pad[j] = cell_data[j];
        end
        else
        begin : g_zero
            assign cell_pad[j] = 8'd0;
        end
    end

    for (genvar i = 0; i < MAX_DELIM; i++)
    begin : g_cell
        logic [7:0] far_byte;

        always_comb
        begin
            far_byte = 8'd0;
            for (int k = 1; k <= DELIM_BYTES; k++)
            begin
                if (len_eff == LEN_W'(k))
                begin
                    far_byte = cell_pad[i + k];
                end
            end
        end

        mds_cell u_cell (
            .clk        (clk),
            .op         (ops[i]),
            .delim_byte (delim_reg[8 * (i % DELIM_BYTES) +: 8]),
            .nbr_byte   (cell_pad[i + 1]),
            .far_byte   (far_byte),
            .load_byte  (in_word.data_byte),
            .data       (cell_data[i]),
            .cmp        (cmp[i])
        );
    end

    mds_ctrl #(
        .MAX_DELIM (MAX_DELIM)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .len_cfg     (len_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .string_last (in_word.string_last),
        .cmp         (cmp),
        .head_byte   (cell_data[0]),
        .ops         (ops),
        .len_eff     (len_eff),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word),
        .count       (count_q),
        .stat        (stat)
    );

    // The chain never holds more bytes than it has cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_q) <= MAX_DELIM)
        else $error("pending byte count exceeds the cell chain");

    // A word carries either a content byte or a field end, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_word.has_byte && out_word.field_end))
        else $error("output word marks both a byte and a field end");

    // The word closing a string is a field end and the last word of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.string_end |-> out_word.field_end && out_word.run_last)
        else $error("string end without field end or run end");

    // A final byte taken with a delimiter in use puts the scan in flush mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_word.string_last && len_eff != '0 |=> stat.last)
        else $error("final byte did not start the flush");

endmodule

`default_nettype wire
